// File: src/pwotx_pkg.sv
`default_nettype none
package pwotx_pkg;

   localparam int unsigned CSR_ADDR_W = 5;
   localparam int unsigned CSR_DATA_W = 32;
   localparam int unsigned TICK_W = 16;

   localparam logic [2:0] REG_START_TICKS = 3'd0;
   localparam logic [2:0] REG_SHORT_TICKS = 3'd1;
   localparam logic [2:0] REG_LONG_TICKS  = 3'd2;
   localparam logic [2:0] REG_POLL_TICKS  = 3'd3;
   localparam logic [2:0] REG_POLL_LIMIT  = 3'd4;

   localparam logic [TICK_W-1:0] START_TICKS_RESET = 16'd5000;
   localparam logic [TICK_W-1:0] SHORT_TICKS_RESET = 16'd500;
   localparam logic [TICK_W-1:0] LONG_TICKS_RESET  = 16'd1500;
   localparam logic [TICK_W-1:0] POLL_TICKS_RESET  = 16'd120;
   localparam logic [TICK_W-1:0] POLL_LIMIT_RESET  = 16'd30000;

   localparam logic OP_TICK = 1'b0;
   localparam logic OP_SEND = 1'b1;

   localparam int unsigned QUEUE_DEPTH = 2;
   localparam int unsigned QPTR_W = $clog2(QUEUE_DEPTH);
   localparam int unsigned QCNT_W = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic       operation;
      logic [7:0] command;
      logic       busy_level;
   } req_type;

   typedef struct packed {
      logic line_level;
      logic ready_res;
      logic finished;
      logic timed_out;
   } rsp_type;

   typedef struct packed {
      logic             is_send;
      logic [7:0]       command;
      logic             busy_level;
   } work_type;

   typedef struct packed {
      logic [TICK_W-1:0] start_ticks;
      logic [TICK_W-1:0] short_ticks;
      logic [TICK_W-1:0] long_ticks;
      logic [TICK_W-1:0] poll_ticks;
      logic [TICK_W-1:0] poll_limit;
   } cfg_type;

   typedef enum logic [4:0] {
      PH_IDLE  = 5'b00001,
      PH_START = 5'b00010,
      PH_HIGH  = 5'b00100,
      PH_LOW   = 5'b01000,
      PH_POLL  = 5'b10000
   } phase_type;

endpackage
`default_nettype wire

// File: src/pulse_width_one_wire_tx_core.sv
// Single-wire command transmitter: every request is one timing tick or a send request, and
// every request produces exactly one result carrying the line level, ready, finished and
// timed_out after it. One request is taken per clock cycle when the result side keeps up,
// and its result is written into the result queue in the same cycle it is accepted; the
// rate is set by the state update of the timing engine. A two-entry request queue feeds the
// engine and a two-entry result queue holds its output, so either side may stall on its
// own. Timing registers take effect when the next line segment loads its length.
`default_nettype none
module pulse_width_one_wire_tx_core
   import pwotx_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  push,
   output logic                       full,
   input  wire req_type               req_data,
   output logic                       empty,
   input  wire logic                  pop,
   output rsp_type                    rsp_data,
   input  wire logic                  psel,
   input  wire logic                  penable,
   input  wire logic                  pwrite,
   input  wire logic [CSR_ADDR_W-1:0] paddr,
   input  wire logic [CSR_DATA_W-1:0] pwdata,
   output logic      [CSR_DATA_W-1:0] prdata,
   output logic                       pready
);

   cfg_type  cfg;
   work_type work;
   logic     work_valid;
   logic     work_take;
   logic     rsp_push;
   logic     rsp_full;
   rsp_type  rsp_result;

   pwotx_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   pwotx_front u_front (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .full       (full),
      .req_data   (req_data),
      .work_valid (work_valid),
      .work_take  (work_take),
      .work       (work)
   );

   pwotx_engine u_engine (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .work_valid (work_valid),
      .work_take  (work_take),
      .work       (work),
      .rsp_push   (rsp_push),
      .rsp_full   (rsp_full),
      .rsp_result (rsp_result)
   );

   pwotx_rsp_queue u_rsp_queue (
      .clock      (clock),
      .reset      (reset),
      .rsp_push   (rsp_push),
      .rsp_full   (rsp_full),
      .rsp_result (rsp_result),
      .empty      (empty),
      .pop        (pop),
      .rsp_data   (rsp_data)
   );

endmodule
`default_nettype wire

// File: src/pwotx_csr.sv
`default_nettype none
module pwotx_csr
   import pwotx_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  psel,
   input  wire logic                  penable,
   input  wire logic                  pwrite,
   input  wire logic [CSR_ADDR_W-1:0] paddr,
   input  wire logic [CSR_DATA_W-1:0] pwdata,
   output logic      [CSR_DATA_W-1:0] prdata,
   output logic                       pready,
   output cfg_type                    cfg
);

   cfg_type    cfg_ff;
   cfg_type    cfg_in;
   logic       wr_en;
   logic [2:0] reg_index;

   assign pready    = 1'b1;
   assign wr_en     = psel & penable & pwrite;
   assign reg_index = paddr[4:2];
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_index)
            REG_START_TICKS: cfg_in.start_ticks = pwdata[TICK_W-1:0];
            REG_SHORT_TICKS: cfg_in.short_ticks = pwdata[TICK_W-1:0];
            REG_LONG_TICKS:  cfg_in.long_ticks  = pwdata[TICK_W-1:0];
            REG_POLL_TICKS:  cfg_in.poll_ticks  = pwdata[TICK_W-1:0];
            REG_POLL_LIMIT:  cfg_in.poll_limit  = pwdata[TICK_W-1:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      prdata = '0;
      unique case (reg_index)
         REG_START_TICKS: prdata[TICK_W-1:0] = cfg_ff.start_ticks;
         REG_SHORT_TICKS: prdata[TICK_W-1:0] = cfg_ff.short_ticks;
         REG_LONG_TICKS:  prdata[TICK_W-1:0] = cfg_ff.long_ticks;
         REG_POLL_TICKS:  prdata[TICK_W-1:0] = cfg_ff.poll_ticks;
         REG_POLL_LIMIT:  prdata[TICK_W-1:0] = cfg_ff.poll_limit;
         default: prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.start_ticks <= START_TICKS_RESET;
         cfg_ff.short_ticks <= SHORT_TICKS_RESET;
         cfg_ff.long_ticks  <= LONG_TICKS_RESET;
         cfg_ff.poll_ticks  <= POLL_TICKS_RESET;
         cfg_ff.poll_limit  <= POLL_LIMIT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule
`default_nettype wire

// File: src/pwotx_front.sv
`default_nettype none
module pwotx_front
   import pwotx_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     push,
   output logic          full,
   input  wire req_type  req_data,
   output logic          work_valid,
   input  wire logic     work_take,
   output work_type      work
);

   work_type          entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff;
   logic [QPTR_W-1:0] wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff;
   logic [QPTR_W-1:0] rd_ptr_in;
   logic [QCNT_W-1:0] count_ff;
   logic [QCNT_W-1:0] count_in;
   logic              do_push;
   logic              do_pop;
   work_type          classified;

   assign full       = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign work_valid = (count_ff != '0);
   assign do_push    = push & ~full;
   assign do_pop     = work_take & work_valid;
   assign work       = entry_ff[rd_ptr_ff];

   always_comb begin
      classified.is_send    = (req_data.operation == OP_SEND);
      classified.command    = req_data.command;
      classified.busy_level = req_data.busy_level;
   end

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= classified;
      end
   end

endmodule
`default_nettype wire

// File: src/pwotx_engine.sv
`default_nettype none
module pwotx_engine
   import pwotx_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire cfg_type  cfg,
   input  wire logic     work_valid,
   output logic          work_take,
   input  wire work_type work,
   output logic          rsp_push,
   input  wire logic     rsp_full,
   output rsp_type       rsp_result
);

   phase_type         phase_ff;
   phase_type         phase_in;
   logic [2:0]        bit_index_ff;
   logic [2:0]        bit_index_in;
   logic [7:0]        shift_ff;
   logic [7:0]        shift_in;
   logic [TICK_W-1:0] time_left_ff;
   logic [TICK_W-1:0] time_left_in;
   logic [TICK_W-1:0] poll_count_ff;
   logic [TICK_W-1:0] poll_count_in;
   logic              line_ff;
   logic              line_in;
   logic              fin;
   logic              tout;
   logic              sample;
   logic [7:0]        next_shift;

   assign work_take = work_valid & ~rsp_full;
   assign rsp_push  = work_take;
   assign next_shift = {1'b0, shift_ff[7:1]};

   always_comb begin
      phase_in      = phase_ff;
      bit_index_in  = bit_index_ff;
      shift_in      = shift_ff;
      time_left_in  = time_left_ff;
      poll_count_in = poll_count_ff;
      line_in       = line_ff;
      fin           = 1'b0;
      tout          = 1'b0;
      sample        = 1'b0;
      if (work.is_send) begin
         if (phase_ff == PH_IDLE) begin
            shift_in      = work.command;
            bit_index_in  = '0;
            poll_count_in = '0;
            phase_in      = PH_START;
            line_in       = 1'b0;
            time_left_in  = cfg.start_ticks;
         end
      end else if (phase_ff != PH_IDLE) begin
         if (time_left_ff > TICK_W'(1)) begin
            time_left_in = time_left_ff - 1'b1;
         end else begin
            time_left_in = '0;
            unique case (phase_ff)
               PH_START: begin
                  phase_in     = PH_HIGH;
                  line_in      = 1'b1;
                  time_left_in = shift_ff[0] ? cfg.long_ticks : cfg.short_ticks;
               end
               PH_HIGH: begin
                  phase_in     = PH_LOW;
                  line_in      = 1'b0;
                  time_left_in = shift_ff[0] ? cfg.short_ticks : cfg.long_ticks;
               end
               PH_LOW: begin
                  if (bit_index_ff == 3'd7) begin
                     sample = 1'b1;
                  end else begin
                     bit_index_in = bit_index_ff + 1'b1;
                     shift_in     = next_shift;
                     phase_in     = PH_HIGH;
                     line_in      = 1'b1;
                     time_left_in = next_shift[0] ? cfg.long_ticks : cfg.short_ticks;
                  end
               end
               PH_POLL: sample = 1'b1;
               default: sample = 1'b1;
            endcase
            if (sample) begin
               line_in = 1'b1;
               if (!work.busy_level) begin
                  fin = 1'b1;
               end else if (poll_count_ff >= cfg.poll_limit) begin
                  fin  = 1'b1;
                  tout = 1'b1;
               end else begin
                  poll_count_in = poll_count_ff + 1'b1;
                  phase_in      = PH_POLL;
                  time_left_in  = cfg.poll_ticks;
               end
            end
            if (fin) begin
               phase_in     = PH_IDLE;
               time_left_in = '0;
            end
         end
      end
   end

   always_comb begin
      rsp_result.line_level = line_in;
      rsp_result.ready_res  = (phase_in == PH_IDLE);
      rsp_result.finished   = fin;
      rsp_result.timed_out  = tout;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_IDLE;
         bit_index_ff  <= '0;
         shift_ff      <= '0;
         time_left_ff  <= '0;
         poll_count_ff <= '0;
         line_ff       <= 1'b1;
      end else if (work_take) begin
         phase_ff      <= phase_in;
         bit_index_ff  <= bit_index_in;
         shift_ff      <= shift_in;
         time_left_ff  <= time_left_in;
         poll_count_ff <= poll_count_in;
         line_ff       <= line_in;
      end
   end

   a_timeout_needs_finish: assert property (@(posedge clock) disable iff (reset)
      rsp_push && rsp_result.timed_out |-> rsp_result.finished)
      else $error("timeout reported without command completion");

   a_idle_after_finish: assert property (@(posedge clock) disable iff (reset)
      rsp_push && rsp_result.finished |=> phase_ff == PH_IDLE)
      else $error("engine not idle after a command completed");

   a_idle_line_high: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_IDLE |-> line_ff)
      else $error("line low while idle");

   a_send_starts_low: assert property (@(posedge clock) disable iff (reset)
      work_take && work.is_send && phase_ff == PH_IDLE |=> phase_ff == PH_START && !line_ff)
      else $error("accepted send did not start the start pulse");

endmodule
`default_nettype wire

// File: src/pwotx_rsp_queue.sv
`default_nettype none
module pwotx_rsp_queue
   import pwotx_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    rsp_push,
   output logic         rsp_full,
   input  wire rsp_type rsp_result,
   output logic         empty,
   input  wire logic    pop,
   output rsp_type      rsp_data
);

   rsp_type           entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff;
   logic [QPTR_W-1:0] wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff;
   logic [QPTR_W-1:0] rd_ptr_in;
   logic [QCNT_W-1:0] count_ff;
   logic [QCNT_W-1:0] count_in;
   logic              do_push;
   logic              do_pop;

   assign rsp_full = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = rsp_push & ~rsp_full;
   assign do_pop   = pop & ~empty;
   assign rsp_data = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= rsp_result;
      end
   end

   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QCNT_W'(QUEUE_DEPTH))
      else $error("result queue count beyond its depth");

   a_push_fills: assert property (@(posedge clock) disable iff (reset)
      do_push && !do_pop |=> !empty)
      else $error("result queue empty after a push");

endmodule
`default_nettype wire
